>>> hw/rtl/rlp_stream_decoder_top_assert.svh
// Assertion macros used by the RLP stream decoder top
`ifndef RLP_STREAM_DECODER_TOP_ASSERT_SVH
`define RLP_STREAM_DECODER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define RLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rlp assertion failed");
// Next-cycle implication checked outside reset
`define RLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rlp assertion failed");
`endif

>>> hw/rtl/rlp_pkg.sv
// Types and constants of the RLP stream decoder
package rlp_pkg;
	localparam int unsigned POS_W = 32;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	typedef enum logic [2:0] {
		KIND_STR_HDR = 3'd0,
		KIND_LIST_HDR = 3'd1,
		KIND_PAYLOAD = 3'd2,
		KIND_SINGLE = 3'd3,
		KIND_IGNORED = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_TRUNC = 3'd1,
		ERR_OVERRUN = 3'd2,
		ERR_DEEP = 3'd3,
		ERR_WIDE = 3'd4
	} err_t;

	localparam logic [7:0] STR_BASE = 8'h80;
	localparam logic [7:0] STR_LONG = 8'hb7;
	localparam logic [7:0] STR_LAST = 8'hbf;
	localparam logic [7:0] LIST_BASE = 8'hc0;
	localparam logic [7:0] LIST_LONG = 8'hf7;

	// Input and result payloads
	typedef struct packed {
		logic [7:0] byte_in;
		logic last_byte;
	} rlp_in_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_out;
		logic [4:0] depth;
		logic string_done;
		logic [4:0] lists_closed;
		logic top_done;
		logic [2:0] error_code;
	} rlp_out_t;
endpackage

>>> hw/rtl/rlp_stream_if.sv
// Valid/ready channel carrying one payload
interface rlp_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/rlp_stream_decoder_top.sv
// Top level of the RLP stream decoder: sequencer, shared compare unit, result register
//
// Channel | Dir | Payload                                             | Transfer
// in_ch   | in  | byte_in, last_byte                                  | valid & ready
// out_ch  | out | kind, data_out, depth, string_done, lists_closed,   | valid & ready
//         |     | top_done, error_code                                |
//
// A byte passes through accept, stack read, decide, pop check, result and hand-off with
// the receiver ready. Ignored and error bytes skip the pop check; a list push adds a
// stack re-read, and every list closed adds a re-read and a compare.
// The result sits in an output register; the next byte is accepted the cycle after it is taken.
// Reset clears all control state; the stack memory needs no clearing.
`include "rlp_stream_decoder_top_assert.svh"
module rlp_stream_decoder_top import rlp_pkg::*; #(
	parameter int unsigned MAX_DEPTH = 16,
	parameter int unsigned LEN_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	rlp_stream_if.sink in_ch,
	rlp_stream_if.source out_ch
);
	localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int unsigned OW = $clog2(MAX_DEPTH + 1);
	localparam int unsigned LW = (LEN_BITS > POS_W) ? LEN_BITS : POS_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EVAL, ST_POP_RD, ST_POP_CMP, ST_OUT
	} state_t;
	typedef enum logic [2:0] {
		PH_PREFIX, PH_LENGTH, PH_PAYLOAD, PH_TRAILING, PH_DISCARD
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic [7:0] byte_q;
	logic last_q;
	logic [OW-1:0] open_q;
	logic [POS_W-1:0] pos_q;
	logic [LW-1:0] len_q;
	logic [3:0] left_q;
	logic is_list_q;
	logic [POS_W-1:0] str_end_q;
	logic [OW-1:0] closed_q;
	logic completed_q;
	logic parsing_q;
	rlp_out_t res_q;
	logic out_valid_q;

	logic st_wr;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [POS_W-1:0] st_wdata, st_rdata;

	rlp_end_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
		.clk(clk), .wr_en(st_wr), .wr_addr(st_waddr), .wr_data(st_wdata),
		.rd_addr(st_raddr), .rd_data(st_rdata)
	);

	logic [POS_W:0] pos_p1;
	assign pos_p1 = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};

	// Read the top entry; during pops the address follows open_q - 1
	logic [OW-1:0] top_idx;
	assign top_idx = open_q - OW'(1);
	assign st_raddr = AW'(top_idx);

	// Header evaluation in ST_EVAL: one add and compare unit
	logic hdr_now;
	logic [LW-1:0] hdr_len;
	logic hdr_list;
	logic [LW-1:0] acc_new;
	logic wide_acc;
	logic [LW:0] end_ext;
	logic [2:0] hdr_err;
	logic [POS_W-1:0] end_pos;
	logic [7:0] b;

	always_comb begin
		b = byte_q;
		hdr_now = 1'b0;
		hdr_len = '0;
		hdr_list = 1'b0;
		wide_acc = 1'b0;
		acc_new = {len_q[LW-9:0], byte_q};
		if (phase_q == PH_PREFIX) begin
			if (b >= STR_BASE && b <= STR_LONG) begin
				hdr_now = 1'b1;
				hdr_len = LW'(b - STR_BASE);
			end else if (b >= LIST_BASE && b <= LIST_LONG) begin
				hdr_now = 1'b1;
				hdr_list = 1'b1;
				hdr_len = LW'(b - LIST_BASE);
			end
		end else if (phase_q == PH_LENGTH) begin
			wide_acc = (len_q >> (LEN_BITS - 8)) != '0;
			hdr_now = !wide_acc && (left_q <= 4'd1);
			hdr_len = acc_new;
			hdr_list = is_list_q;
		end
		end_ext = {1'b0, hdr_len} + (LW+1)'(pos_q) + (LW+1)'(1);
		end_pos = end_ext[POS_W-1:0];
		hdr_err = ERR_NONE;
		if (wide_acc) begin
			hdr_err = ERR_WIDE;
		end else if (hdr_now) begin
			if ((LW > POS_W && (hdr_len >> POS_W) != '0) || end_ext > (LW+1)'(POS_MAX)) begin
				hdr_err = ERR_WIDE;
			end else if (open_q != '0 && end_ext > (LW+1)'(st_rdata)) begin
				hdr_err = ERR_OVERRUN;
			end else if (hdr_list && open_q >= OW'(MAX_DEPTH)) begin
				hdr_err = ERR_DEEP;
			end
		end
	end

	assign st_wr = (state_q == ST_EVAL) && hdr_now && hdr_list && hdr_err == ERR_NONE;
	assign st_waddr = AW'(open_q);
	assign st_wdata = end_pos;

	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = res_q;

	logic pop_hit;
	assign pop_hit = open_q != '0 && {1'b0, st_rdata} == pos_p1;

	// Sequencer: state, parse state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_PREFIX;
			open_q <= '0;
			pos_q <= '0;
			len_q <= '0;
			left_q <= '0;
			is_list_q <= 1'b0;
			str_end_q <= '0;
			closed_q <= '0;
			completed_q <= 1'b0;
			parsing_q <= 1'b0;
			out_valid_q <= 1'b0;
			byte_q <= '0;
			last_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						byte_q <= in_ch.data.byte_in;
						last_q <= in_ch.data.last_byte;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					res_q <= '0;
					res_q.data_out <= byte_q;
					res_q.kind <= KIND_IGNORED;
					closed_q <= '0;
					completed_q <= 1'b0;
					parsing_q <= phase_q == PH_PREFIX || phase_q == PH_LENGTH ||
						phase_q == PH_PAYLOAD;
					state_q <= ST_POP_CMP;
					if (phase_q == PH_PREFIX || phase_q == PH_LENGTH ||
							phase_q == PH_PAYLOAD) begin
						res_q.depth <= 5'(open_q);
					end
					unique case (phase_q)
						PH_PREFIX: begin
							if (byte_q < STR_BASE) begin
								res_q.kind <= KIND_SINGLE;
								res_q.string_done <= 1'b1;
								completed_q <= 1'b1;
							end else if (byte_q <= STR_LAST) begin
								res_q.kind <= KIND_STR_HDR;
							end else begin
								res_q.kind <= KIND_LIST_HDR;
							end
							if ((byte_q > STR_LONG && byte_q <= STR_LAST) ||
									byte_q > LIST_LONG) begin
								len_q <= '0;
								left_q <= (byte_q > LIST_LONG) ? 4'(byte_q - LIST_LONG) :
									4'(byte_q - STR_LONG);
								is_list_q <= byte_q > LIST_LONG;
								phase_q <= PH_LENGTH;
							end
						end
						PH_LENGTH: begin
							res_q.kind <= is_list_q ? KIND_LIST_HDR : KIND_STR_HDR;
							if (!wide_acc) begin
								len_q <= acc_new;
								if (left_q != '0) begin
									left_q <= left_q - 4'd1;
								end
							end
						end
						PH_PAYLOAD: begin
							res_q.kind <= KIND_PAYLOAD;
							if (pos_p1 >= {1'b0, str_end_q}) begin
								res_q.string_done <= 1'b1;
								completed_q <= 1'b1;
								phase_q <= PH_PREFIX;
							end
						end
						default: begin
						end
					endcase
					// Header completion
					if (hdr_err != ERR_NONE) begin
						res_q.error_code <= hdr_err;
						res_q.string_done <= 1'b0;
						phase_q <= PH_DISCARD;
						parsing_q <= 1'b0;
						state_q <= ST_OUT;
					end else if (hdr_now) begin
						if (hdr_list) begin
							open_q <= open_q + OW'(1);
							phase_q <= PH_PREFIX;
							state_q <= ST_POP_RD;
						end else if (hdr_len == '0) begin
							res_q.string_done <= 1'b1;
							completed_q <= 1'b1;
							phase_q <= PH_PREFIX;
						end else begin
							str_end_q <= end_pos;
							phase_q <= PH_PAYLOAD;
						end
					end
					if (!(phase_q == PH_PREFIX || phase_q == PH_LENGTH ||
							phase_q == PH_PAYLOAD)) begin
						state_q <= ST_OUT;
					end
				end
				ST_POP_RD: begin
					state_q <= ST_POP_CMP;
				end
				ST_POP_CMP: begin
					if (pop_hit) begin
						open_q <= open_q - OW'(1);
						closed_q <= closed_q + OW'(1);
						completed_q <= 1'b1;
						state_q <= ST_POP_RD;
					end else begin
						res_q.lists_closed <= 5'(closed_q);
						if (completed_q && open_q == '0) begin
							res_q.top_done <= 1'b1;
							phase_q <= PH_TRAILING;
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Truncation check, end of buffer, position update
					if (last_q) begin
						if (res_q.error_code == ERR_NONE && parsing_q &&
								phase_q != PH_TRAILING) begin
							res_q.error_code <= ERR_TRUNC;
							res_q.string_done <= 1'b0;
							res_q.lists_closed <= '0;
							res_q.top_done <= 1'b0;
						end
						phase_q <= PH_PREFIX;
						open_q <= '0;
						pos_q <= '0;
						len_q <= '0;
						left_q <= '0;
						is_list_q <= 1'b0;
						str_end_q <= '0;
					end else if (pos_q != POS_MAX) begin
						pos_q <= pos_q + POS_W'(1);
					end
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`RLP_ASSERT_IMP(a_open_bound, clk, arst_n, 1'b1, open_q <= OW'(MAX_DEPTH))
	`RLP_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !in_ch.ready)
	`RLP_ASSERT_NXT(a_result_after_out, clk, arst_n, state_q == ST_OUT, out_valid_q)
	`RLP_ASSERT_IMP(a_err_quiet, clk, arst_n, out_valid_q && res_q.error_code != ERR_NONE,
		!res_q.top_done && !res_q.string_done)
endmodule

>>> hw/rtl/rlp_end_stack.sv
// Stack of list end positions, one push and one read per cycle
module rlp_end_stack import rlp_pkg::*; #(
	parameter int unsigned MAX_DEPTH = 16,
	localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [POS_W-1:0] wr_data,
	input logic [AW-1:0] rd_addr,
	output logic [POS_W-1:0] rd_data
);
	logic [POS_W-1:0] mem [MAX_DEPTH];

	// Registered read, one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

>>> test/rlp_decode_checker.sv
// Checker for the RLP stream decoder: predicts each token and compares it with the output
module rlp_decode_checker import rlp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input rlp_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input rlp_out_t out_data,
	output int mismatches,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned LEN_W = 32;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_TRAILING,
		PH_DISCARD
	} phase_t;

	// Decoder state as the checker tracks it
	logic [31:0] end_stack [STACK_DEPTH];
	int unsigned open_cnt;
	logic [31:0] pos;
	phase_t phase;
	logic [63:0] len_acc;
	int unsigned len_left;
	logic hdr_list;
	logic [31:0] str_end;

	rlp_out_t token_q [$];

	assign pending = token_q.size();

	function automatic void clear_state();
		open_cnt = 0;
		pos = '0;
		phase = PH_PREFIX;
		len_acc = '0;
		len_left = 0;
		hdr_list = 1'b0;
		str_end = '0;
	endfunction

	// A header has been read completely; returns the error it raises
	function automatic err_t close_header(logic [63:0] p, logic [63:0] len, logic is_list,
		inout logic sdone, inout logic done);
		logic [63:0] fin;
		if (len > 64'h0000_0000_ffff_ffff) return ERR_WIDE;
		fin = p + 64'd1 + len;
		if (fin > 64'h0000_0000_ffff_ffff) return ERR_WIDE;
		if (open_cnt > 0 && fin > {32'd0, end_stack[open_cnt-1]}) return ERR_OVERRUN;
		if (is_list) begin
			if (open_cnt >= STACK_DEPTH) return ERR_DEEP;
			end_stack[open_cnt] = fin[31:0];
			open_cnt++;
			phase = PH_PREFIX;
		end else if (len == 0) begin
			sdone = 1'b1;
			done = 1'b1;
			phase = PH_PREFIX;
		end else begin
			str_end = fin[31:0];
			phase = PH_PAYLOAD;
		end
		return ERR_NONE;
	endfunction

	// Token expected for one byte, advancing the tracked state
	function automatic rlp_out_t decode_byte(rlp_in_t x);
		rlp_out_t t;
		logic [63:0] p;
		logic [7:0] b;
		kind_t kind;
		err_t err;
		logic sdone, done, tdone, parsing;
		int unsigned depth, closed;
		b = x.byte_in;
		p = {32'd0, pos};
		kind = KIND_IGNORED;
		err = ERR_NONE;
		depth = 0;
		closed = 0;
		sdone = 1'b0;
		done = 1'b0;
		tdone = 1'b0;
		parsing = (phase == PH_PREFIX || phase == PH_LENGTH || phase == PH_PAYLOAD);
		case (phase)
			PH_PREFIX: begin
				depth = open_cnt;
				if (b < STR_BASE) begin
					kind = KIND_SINGLE;
					sdone = 1'b1;
					done = 1'b1;
				end else if (b <= STR_LONG) begin
					kind = KIND_STR_HDR;
					err = close_header(p, 64'(b - STR_BASE), 1'b0, sdone, done);
				end else if (b <= STR_LAST) begin
					kind = KIND_STR_HDR;
					len_acc = '0;
					len_left = b - STR_LONG;
					hdr_list = 1'b0;
					phase = PH_LENGTH;
				end else if (b <= LIST_LONG) begin
					kind = KIND_LIST_HDR;
					err = close_header(p, 64'(b - LIST_BASE), 1'b1, sdone, done);
				end else begin
					kind = KIND_LIST_HDR;
					len_acc = '0;
					len_left = b - LIST_LONG;
					hdr_list = 1'b1;
					phase = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				kind = hdr_list ? KIND_LIST_HDR : KIND_STR_HDR;
				depth = open_cnt;
				if ((len_acc >> (LEN_W - 8)) != 0) begin
					err = ERR_WIDE;
				end else begin
					len_acc = (len_acc << 8) | 64'(b);
					if (len_left > 0) len_left--;
					if (len_left == 0) err = close_header(p, len_acc, hdr_list, sdone, done);
				end
			end
			PH_PAYLOAD: begin
				kind = KIND_PAYLOAD;
				depth = open_cnt;
				if (p + 64'd1 >= {32'd0, str_end}) begin
					sdone = 1'b1;
					done = 1'b1;
					phase = PH_PREFIX;
				end
			end
			default: ;
		endcase

		// Errors drop into discard; otherwise pop every list ending here
		if (err != ERR_NONE) begin
			phase = PH_DISCARD;
			sdone = 1'b0;
		end else if (parsing) begin
			while (open_cnt > 0 && {32'd0, end_stack[open_cnt-1]} == p + 64'd1) begin
				open_cnt--;
				closed++;
				done = 1'b1;
			end
			if (done && open_cnt == 0) begin
				tdone = 1'b1;
				phase = PH_TRAILING;
			end
		end

		// Last byte: flag truncation, then start over for the next buffer
		if (x.last_byte) begin
			if (err == ERR_NONE && parsing && phase != PH_TRAILING) begin
				err = ERR_TRUNC;
				sdone = 1'b0;
				closed = 0;
				tdone = 1'b0;
			end
			clear_state();
		end else if (pos != POS_MAX) begin
			pos++;
		end

		t.kind = kind;
		t.data_out = b;
		t.depth = depth[4:0];
		t.string_done = sdone;
		t.lists_closed = closed[4:0];
		t.top_done = tdone;
		t.error_code = err;
		return t;
	endfunction

	initial begin
		mismatches = 0;
		clear_state();
	end

	// Predict on every input transfer, compare on every output transfer
	always @(posedge clk) begin
		rlp_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) token_q.push_back(decode_byte(in_data));
			if (out_valid && out_ready) begin
				if (token_q.size() == 0) begin
					$error("unexpected token transfer: %p", out_data);
					mismatches++;
				end else begin
					want = token_q.pop_front();
					if (out_data.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, out_data.kind);
						mismatches++;
					end
					if (out_data.data_out !== want.data_out) begin
						$error("data_out: expected %h, got %h", want.data_out, out_data.data_out);
						mismatches++;
					end
					if (out_data.depth !== want.depth) begin
						$error("depth: expected %0d, got %0d", want.depth, out_data.depth);
						mismatches++;
					end
					if (out_data.string_done !== want.string_done) begin
						$error("string_done: expected %0d, got %0d", want.string_done,
							out_data.string_done);
						mismatches++;
					end
					if (out_data.lists_closed !== want.lists_closed) begin
						$error("lists_closed: expected %0d, got %0d", want.lists_closed,
							out_data.lists_closed);
						mismatches++;
					end
					if (out_data.top_done !== want.top_done) begin
						$error("top_done: expected %0d, got %0d", want.top_done,
							out_data.top_done);
						mismatches++;
					end
					if (out_data.error_code !== want.error_code) begin
						$error("error_code: expected %0d, got %0d", want.error_code,
							out_data.error_code);
						mismatches++;
					end
				end
			end
		end
	end
endmodule

>>> test/tb.sv
// Testbench top for the RLP stream decoder: buffer stimulus, flow control and verdict
module tb;
	import rlp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef byte unsigned bytes_t [$];

	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_TARGET = 1100;

	logic clk;
	logic arst_n;
	int cycles;
	int sent;
	int mode;
	int stall_len;
	int mismatches;
	int pending;

	rlp_stream_if #(.payload_t(rlp_in_t)) in_ch ();
	rlp_stream_if #(.payload_t(rlp_out_t)) out_ch ();

	rlp_stream_decoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	rlp_decode_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Receiver: random stalls by mode, plus long hold-offs on request
	initial begin
		int hold;
		hold = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_len > 0) begin
				hold = stall_len;
				stall_len = 0;
			end
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (mode == 2 || mode == 3) begin
				out_ch.ready <= ($urandom_range(0, 99) >= (mode == 2 ? 81 : 38));
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	function automatic bytes_t hdr(byte unsigned short_base, int len);
		bytes_t q;
		if (len < 56 && $urandom_range(0, 9) != 0) begin
			q = '{8'(short_base + len)};
		end else if (len < 256) begin
			q = '{8'(short_base + 56), 8'(len)};
		end else begin
			q = '{8'(short_base + 57), 8'(len >> 8), 8'(len)};
		end
		return q;
	endfunction

	// One random well-formed item, lists nested a few levels at most
	function automatic bytes_t gen_item(int lvl);
		bytes_t q, body;
		int r, n;
		r = $urandom_range(0, 9);
		if (lvl >= 3 || r < 5) begin
			r = $urandom_range(0, 9);
			if (r < 2) return '{8'($urandom_range(0, 127))};
			n = (r == 9) ? $urandom_range(55, 58) : $urandom_range(0, 3);
			repeat (n) body.push_back(8'($urandom));
			q = {hdr(STR_BASE, n), body};
		end else begin
			n = $urandom_range(0, 3);
			repeat (n) body = {body, gen_item(lvl + 1)};
			q = {hdr(LIST_BASE, body.size()), body};
		end
		return q;
	endfunction

	function automatic bytes_t nest(int n);
		bytes_t q;
		q = '{LIST_BASE};
		repeat (n - 1) q = {8'(LIST_BASE + q.size()), q};
		return q;
	endfunction

	task automatic send_byte(byte unsigned b, logic last);
		int gap;
		gap = (mode == 1) ? 81 : (mode == 3 ? 38 : 0);
		while (gap > 0 && $urandom_range(0, 99) < gap) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{byte_in: b, last_byte: last};
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	task automatic send_buf(bytes_t q);
		for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
	endtask

	// Random buffer: mostly well formed, some cut, padded, corrupted, deeply nested or noise
	function automatic bytes_t rand_buf();
		bytes_t q;
		int m;
		m = $urandom_range(0, 99);
		if (m >= 94) begin
			q = '{};
			repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
		end else if (m >= 91) begin
			q = nest($urandom_range(15, 18));
		end else begin
			q = gen_item(0);
			if (m >= 84) begin
				q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
			end else if (m >= 77 && q.size() > 1) begin
				q = q[0 : $urandom_range(0, q.size() - 2)];
			end else if (m >= 70) begin
				repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
			end
		end
		return q;
	endfunction

	initial begin
		int phase_items;
		mode = 0;
		sent = 0;
		stall_len = 0;
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed buffers: byte ranges, long forms, each error, multi-close, trailing
		send_buf('{8'h00});
		send_buf('{8'h7f});
		send_buf('{8'h80});
		send_buf('{8'hbf, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'haa});
		send_buf('{8'hc0});
		send_buf('{8'hf8, 8'h00});
		send_buf('{8'hc1, 8'hc0});
		send_buf('{8'hc4, 8'hc2, 8'hc1, 8'hc0, 8'h01});
		send_buf('{8'hbc, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55});
		send_buf('{8'hbb, 8'hff, 8'hff, 8'hff, 8'hff});
		send_buf('{8'hc1, 8'h82, 8'haa, 8'hbb});
		send_buf('{8'h83, 8'haa});
		send_buf('{8'hc3, 8'h01});
		send_buf('{8'h01, 8'h55, 8'hff});
		send_buf('{8'hff, 8'h01, 8'h02});
		send_buf(nest(16));
		send_buf(nest(17));

		// Random buffers across the flow-control modes
		phase_items = ITEM_TARGET / 4;
		for (int k = 0; k < 4; k++) begin
			mode = k;
			for (int start = sent; sent - start < phase_items; ) begin
				if (k == 0 && sent - start > 40 && sent - start < 60) stall_len = 400;
				send_buf(rand_buf());
			end
		end
		in_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
